>>> hdl/pcaw_pkg.sv
// Package for the PID controller with angle wrap: widths, constants and codes.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package pcaw_pkg;

  // Field widths
  localparam int ACT_W  = 2;
  localparam int VAL_W  = 32;
  localparam int DT_W   = 24;
  localparam int ANG_W  = 19;
  localparam int IDX_W  = 3;

  // Shared unit widths
  localparam int MUL_W  = 33;            // signed operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int SH_W   = PROD_W - 16;   // product after the Q16 shift
  localparam int DIV_W  = 49;            // dividend magnitude width
  localparam int DIV_CW = 6;             // divider step counter width

  // Q16.16 constants
  localparam logic signed [19:0] FX_PI     = 20'sd205887;
  localparam logic signed [19:0] FX_TWO_PI = 20'sd411775;
  localparam logic signed [31:0] LIN_ILIM  = 32'sd3276800;
  localparam logic signed [31:0] CIRC_ILIM = 32'sd131072;

  // floor(2^50 / TWO_PI); quotient estimate for the angle wrap is off by at most one
  localparam logic signed [MUL_W-1:0] WRAP_RCP = 33'sd2734259988;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LINEAR   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CIRCULAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESET    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UNUSED   = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_MIN     = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_MAX     = 3'd4;
  localparam logic [IDX_W-1:0] REG_START_ANGLE = 3'd5;

  // Register reset values
  localparam logic signed [31:0] OUT_MIN_RST = -32'sd16711680;
  localparam logic signed [31:0] OUT_MAX_RST = 32'sd16711680;

endpackage

>>> hdl/pcaw_if.sv
// Channel interfaces for the PID controller: input items, results, register writes.
// Depends on pcaw_pkg for field widths.
`timescale 1ns / 1ps

interface pcaw_in_if;
  logic                              valid;
  logic                              ready;
  logic [pcaw_pkg::ACT_W-1:0]        action;
  logic signed [pcaw_pkg::VAL_W-1:0] setpoint;
  logic signed [pcaw_pkg::VAL_W-1:0] measured;
  logic [pcaw_pkg::DT_W-1:0]         step_time;
  modport source (output valid, action, setpoint, measured, step_time, input ready);
  modport sink   (input valid, action, setpoint, measured, step_time, output ready);
endinterface

interface pcaw_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pcaw_pkg::VAL_W-1:0] drive;
  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

interface pcaw_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pcaw_pkg::IDX_W-1:0]   index;
  logic [pcaw_pkg::VAL_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/pcaw_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pcaw_pkg for operand widths.
`timescale 1ns / 1ps

module pcaw_mul (
  input  logic                                 clk,
  input  logic signed [pcaw_pkg::MUL_W-1:0]    a,
  input  logic signed [pcaw_pkg::MUL_W-1:0]    b,
  output logic signed [pcaw_pkg::PROD_W-1:0]   p
);

  // One product per cycle, registered
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> hdl/pcaw_div.sv
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// Depends on pcaw_pkg for widths.
`timescale 1ns / 1ps

module pcaw_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pcaw_pkg::DIV_W-1:0]    dividend,
  input  logic [pcaw_pkg::DT_W-1:0]     divisor,
  output logic                          done,
  output logic [pcaw_pkg::DIV_W-1:0]    quot
);

  logic                          busy;
  logic [pcaw_pkg::DIV_CW-1:0]   cnt;
  logic [pcaw_pkg::DT_W-1:0]     dvs;
  logic [pcaw_pkg::DT_W-1:0]     rem;
  logic [pcaw_pkg::DT_W:0]       trial;
  logic                          fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem, quot[pcaw_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= pcaw_pkg::DIV_CW'(pcaw_pkg::DIV_W);
        dvs  <= divisor;
        quot <= dividend;
        rem  <= '0;
      end else if (busy) begin
        rem  <= fits ? pcaw_pkg::DT_W'(trial - {1'b0, dvs}) : trial[pcaw_pkg::DT_W-1:0];
        quot <= {quot[pcaw_pkg::DIV_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == pcaw_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/pid_controller_angle_wrap_core.sv
// PID step in Q16.16 with anti-windup and angle wrap, one shared multiplier and serial divider.
// Linear step: integral, derivative divide and three gain products; circular step adds the rate
// product and two reciprocal-multiply angle wraps. Zero time step: drive of zero. Reset action: none.
// One item at a time: the next input is taken only after the result is loaded into the output
// register, which waits while the previous result is still held there; the derivative divide dominates.
// Reset (rst, synchronous) restores register defaults and clears integral, last error, target.
`timescale 1ns / 1ps

module pid_controller_angle_wrap_core (
  input  logic           clk,
  input  logic           rst,
  pcaw_in_if.sink        in_ch,
  pcaw_out_if.source     out_ch,
  pcaw_cfg_if.sink       cfg_ch
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'b000000000000001,
    S_MUL_INC = 15'b000000000000010,
    S_WRAP_T  = 15'b000000000000100,
    S_WRAP_E  = 15'b000000000001000,
    S_RCP     = 15'b000000000010000,
    S_QMUL    = 15'b000000000100000,
    S_RSUB    = 15'b000000001000000,
    S_MUL_I   = 15'b000000010000000,
    S_INTEG   = 15'b000000100000000,
    S_WAIT_D  = 15'b000001000000000,
    S_MUL_P   = 15'b000010000000000,
    S_MUL_GI  = 15'b000100000000000,
    S_MUL_GD  = 15'b001000000000000,
    S_FIN     = 15'b010000000000000,
    S_DONE    = 15'b100000000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic signed [31:0] gain_p, gain_i, gain_d, out_min, out_max;

  // Controller state
  logic signed [31:0] integral_sum, previous_error, target_angle;

  // Latched item and working registers
  logic signed [31:0] sp, meas, err, rate;
  logic [23:0]        dt;
  logic               circ, bypass, wneg, dneg, wsel;
  logic [31:0]        wmag;
  logic signed [51:0] sum;
  logic               out_valid;
  logic signed [31:0] drive;

  // Shared units
  logic signed [pcaw_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [pcaw_pkg::PROD_W-1:0] mul_p;
  logic                               div_start, div_done;
  logic [pcaw_pkg::DIV_W-1:0]         div_dividend, div_quot;
  logic [23:0]                        div_divisor;

  pcaw_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  pcaw_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quot(div_quot)
  );

  logic signed [pcaw_pkg::SH_W-1:0] prod_sh;
  logic signed [19:0]  inc_sat;
  logic signed [33:0]  wrap_x, diff;
  logic [33:0]         wrap_mag, diff_mag;
  logic [13:0]         wq;
  logic [31:0]         rsub;
  logic [19:0]         rraw, rmod;
  logic signed [19:0]  rem_s, wrap_a, wrap_r;
  logic signed [49:0]  quot_s;
  logic signed [31:0]  rate_sat, ilim, err_lin;
  logic signed [50:0]  iacc;
  logic signed [31:0]  iclamp;
  logic signed [32:0]  lin_diff;
  logic signed [31:0]  drive_clamp;
  logic                in_reset;

  // Product floored by 2^16
  assign prod_sh = mul_p[pcaw_pkg::PROD_W-1:16];

  // Rate increment, saturated to +-pi
  always_comb begin
    if (prod_sh > pcaw_pkg::SH_W'(pcaw_pkg::FX_PI))
      inc_sat = pcaw_pkg::FX_PI;
    else if (prod_sh < -pcaw_pkg::SH_W'(pcaw_pkg::FX_PI))
      inc_sat = -pcaw_pkg::FX_PI;
    else
      inc_sat = prod_sh[19:0];
  end

  // Value to be wrapped: advanced target, or target minus measured
  assign wrap_x   = (state == S_WRAP_T) ? (34'(target_angle) + 34'(inc_sat))
                                        : (34'(target_angle) - 34'(meas));
  assign wrap_mag = wrap_x[33] ? 34'(-wrap_x) : wrap_x;

  // Error change for the derivative
  assign diff     = 34'(err) - 34'(previous_error);
  assign diff_mag = diff[33] ? 34'(-diff) : diff;

  // Divider only serves the derivative rate
  assign div_start    = (state == S_INTEG);
  assign div_dividend = {diff_mag[32:0], 16'd0};
  assign div_divisor  = dt;

  // Angle wrap: quotient estimate from the reciprocal product, one correction step
  assign wq   = mul_p[63:50];
  assign rsub = wmag - mul_p[31:0];
  assign rraw = rsub[19:0];
  assign rmod = (rraw >= $unsigned(pcaw_pkg::FX_TWO_PI))
                ? rraw - $unsigned(pcaw_pkg::FX_TWO_PI) : rraw;

  // Floor modulo fixup into [-pi, pi]
  assign rem_s  = $signed({1'b0, rmod[18:0]});
  assign wrap_a = (wneg && rem_s != 20'sd0) ? pcaw_pkg::FX_TWO_PI - rem_s : rem_s;
  assign wrap_r = (wrap_a > pcaw_pkg::FX_PI) ? wrap_a - pcaw_pkg::FX_TWO_PI : wrap_a;

  // Derivative rate, truncated toward zero, saturated
  assign quot_s = dneg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
  always_comb begin
    if (quot_s > 50'sh7FFFFFFF)       rate_sat = 32'sh7FFFFFFF;
    else if (quot_s < -50'sh80000000) rate_sat = -32'sh80000000;
    else                              rate_sat = quot_s[31:0];
  end

  // Integral accumulate and clamp
  assign ilim = circ ? pcaw_pkg::CIRC_ILIM : pcaw_pkg::LIN_ILIM;
  assign iacc = 51'(integral_sum) + 51'(prod_sh);
  always_comb begin
    if (iacc > 51'(ilim))       iclamp = ilim;
    else if (iacc < -51'(ilim)) iclamp = -ilim;
    else                        iclamp = iacc[31:0];
  end

  // Linear error, saturated
  assign lin_diff = 33'(in_ch.setpoint) - 33'(in_ch.measured);
  always_comb begin
    if (lin_diff > 33'sh07FFFFFFF)       err_lin = 32'sh7FFFFFFF;
    else if (lin_diff < -33'sh080000000) err_lin = -32'sh80000000;
    else                                 err_lin = lin_diff[31:0];
  end

  // Output clamp; when the limits cross, values below the lower limit take it, all others the upper
  always_comb begin
    if (sum < 52'(out_min))      drive_clamp = out_min;
    else if (sum > 52'(out_max)) drive_clamp = out_max;
    else                         drive_clamp = sum[31:0];
  end

  // Multiplier operand select
  always_comb begin
    mul_a = 33'(sp);
    mul_b = $signed({9'd0, dt});
    unique case (state)
      S_RCP: begin
        mul_a = $signed({1'b0, wmag});
        mul_b = pcaw_pkg::WRAP_RCP;
      end
      S_QMUL: begin
        mul_a = $signed({19'd0, wq});
        mul_b = 33'(pcaw_pkg::FX_TWO_PI);
      end
      S_MUL_I: mul_a = 33'(err);
      S_MUL_P: begin
        mul_a = 33'(gain_p);
        mul_b = 33'(err);
      end
      S_MUL_GI: begin
        mul_a = 33'(gain_i);
        mul_b = 33'(integral_sum);
      end
      S_MUL_GD: begin
        mul_a = 33'(gain_d);
        mul_b = 33'(rate);
      end
      default: ;
    endcase
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.drive = drive;
  assign in_reset     = in_ch.valid && in_ch.ready && (in_ch.action == pcaw_pkg::ACT_RESET);

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      out_min        <= pcaw_pkg::OUT_MIN_RST;
      out_max        <= pcaw_pkg::OUT_MAX_RST;
      integral_sum   <= '0;
      previous_error <= '0;
      target_angle   <= '0;
    end else begin
      // Result register: load when free or draining, clear on transfer
      if (state == S_DONE && (!out_valid || out_ch.ready)) out_valid <= 1'b1;
      else if (out_ch.ready)                               out_valid <= 1'b0;

      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          pcaw_pkg::REG_GAIN_P:      gain_p  <= cfg_ch.data;
          pcaw_pkg::REG_GAIN_I:      gain_i  <= cfg_ch.data;
          pcaw_pkg::REG_GAIN_D:      gain_d  <= cfg_ch.data;
          pcaw_pkg::REG_OUT_MIN:     out_min <= cfg_ch.data;
          pcaw_pkg::REG_OUT_MAX:     out_max <= cfg_ch.data;
          pcaw_pkg::REG_START_ANGLE: begin
            // a reset action in the same cycle loads the target afterwards
            if (!in_reset)
              target_angle <= 32'($signed(cfg_ch.data[pcaw_pkg::ANG_W-1:0]));
          end
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            sp     <= in_ch.setpoint;
            meas   <= in_ch.measured;
            dt     <= in_ch.step_time;
            circ   <= (in_ch.action == pcaw_pkg::ACT_CIRCULAR);
            bypass <= (in_ch.step_time == '0);
            err    <= err_lin;
            if (in_ch.action == pcaw_pkg::ACT_RESET) begin
              integral_sum   <= '0;
              previous_error <= '0;
              target_angle   <= in_ch.measured;
            end else if (in_ch.action == pcaw_pkg::ACT_LINEAR ||
                         in_ch.action == pcaw_pkg::ACT_CIRCULAR) begin
              if (in_ch.step_time == '0) begin
                state <= S_DONE;
              end else if (in_ch.action == pcaw_pkg::ACT_CIRCULAR) begin
                state <= S_MUL_INC;
              end else begin
                state <= S_MUL_I;
              end
            end
          end
        end
        S_MUL_INC: state <= S_WRAP_T;
        S_WRAP_T: begin
          wneg  <= wrap_x[33];
          wmag  <= wrap_mag[31:0];
          wsel  <= 1'b0;
          state <= S_RCP;
        end
        S_WRAP_E: begin
          wneg  <= wrap_x[33];
          wmag  <= wrap_mag[31:0];
          wsel  <= 1'b1;
          state <= S_RCP;
        end
        S_RCP:  state <= S_QMUL;
        S_QMUL: state <= S_RSUB;
        S_RSUB: begin
          if (wsel) begin
            err   <= 32'(wrap_r);
            state <= S_MUL_I;
          end else begin
            target_angle <= 32'(wrap_r);
            state        <= S_WRAP_E;
          end
        end
        S_MUL_I: state <= S_INTEG;
        S_INTEG: begin
          integral_sum   <= iclamp;
          dneg           <= diff[33];
          previous_error <= err;
          state          <= S_WAIT_D;
        end
        S_WAIT_D: if (div_done) begin
          rate  <= rate_sat;
          state <= S_MUL_P;
        end
        S_MUL_P:  state <= S_MUL_GI;
        S_MUL_GI: begin
          sum   <= 52'(prod_sh);
          state <= S_MUL_GD;
        end
        S_MUL_GD: begin
          sum   <= sum + 52'(prod_sh);
          state <= S_FIN;
        end
        S_FIN: begin
          sum   <= sum + 52'(prod_sh);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            drive <= bypass ? 32'sd0 : drive_clamp;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Reset action clears the integral and the last error
  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.action == pcaw_pkg::ACT_RESET)
      |=> (integral_sum == 32'sd0 && previous_error == 32'sd0))
    else $error("reset action left integral or last error set");

  // Divider completes only while the sequencer waits on it
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_WAIT_D))
    else $error("divider finished outside the wait state");

  // Anti-windup keeps the integral inside the linear limit
  a_integral_bound: assert property (@(posedge clk) disable iff (rst)
    (integral_sum <= pcaw_pkg::LIN_ILIM && integral_sum >= -pcaw_pkg::LIN_ILIM))
    else $error("integral outside its limit");

  // A new result is loaded only when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ch.ready) |=> state == S_DONE)
    else $error("result overwritten before transfer");

endmodule

>>> verif/pcaw_checker.sv
// Checker for the PID controller with angle wrap: watches the input, result and register
// channels, predicts each drive value and compares it. Depends on pcaw_pkg and pcaw_if.
`timescale 1ns / 1ps

module pcaw_checker (
  input  logic clk,
  input  logic rst,
  pcaw_in_if   in_ch,
  pcaw_out_if  out_ch,
  pcaw_cfg_if  cfg_ch,
  output int   fail_count,
  output int   drives_pending
);

  // Mirrored registers and controller state
  logic signed [31:0] kp, ki, kd, lo_lim, hi_lim;
  logic signed [31:0] integ, last_err, tgt_angle;
  logic signed [31:0] drive_q[$];

  localparam longint PI_L   = 205887;
  localparam longint TPI_L  = 411775;
  localparam longint I32MIN = -64'sd2147483648;
  localparam longint I32MAX = 64'sd2147483647;

  function automatic longint clampl(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint wrap_pi(longint x);
    longint r;
    r = x % TPI_L;
    if (r < 0) r += TPI_L;
    if (r > PI_L) r -= TPI_L;
    return r;
  endfunction

  // One PID update; arithmetic shift of a signed 64-bit product rounds toward minus infinity
  function automatic logic signed [31:0] pid_update(logic signed [31:0] err,
                                                    logic [23:0] dt, longint ilim);
    longint acc, rate, sum, dtl;
    dtl = longint'(dt);
    acc = longint'(integ) + ((longint'(err) * dtl) >>> 16);
    integ = 32'(clampl(acc, -ilim, ilim));
    rate = clampl(((longint'(err) - longint'(last_err)) * 65536) / dtl, I32MIN, I32MAX);
    last_err = err;
    sum = ((longint'(kp) * longint'(err)) >>> 16)
        + ((longint'(ki) * longint'(integ)) >>> 16)
        + ((longint'(kd) * rate) >>> 16);
    if (sum < longint'(lo_lim)) return lo_lim;
    if (sum > longint'(hi_lim)) return hi_lim;
    return 32'(sum);
  endfunction

  always @(posedge clk) begin
    longint inc;
    logic signed [31:0] err;
    if (rst) begin
      kp = 0; ki = 0; kd = 0;
      lo_lim = pcaw_pkg::OUT_MIN_RST; hi_lim = pcaw_pkg::OUT_MAX_RST;
      integ = 0; last_err = 0; tgt_angle = 0;
      drive_q.delete();
      fail_count = 0;
    end else begin
      // Register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          pcaw_pkg::REG_GAIN_P:      kp = cfg_ch.data;
          pcaw_pkg::REG_GAIN_I:      ki = cfg_ch.data;
          pcaw_pkg::REG_GAIN_D:      kd = cfg_ch.data;
          pcaw_pkg::REG_OUT_MIN:     lo_lim = cfg_ch.data;
          pcaw_pkg::REG_OUT_MAX:     hi_lim = cfg_ch.data;
          pcaw_pkg::REG_START_ANGLE:
            tgt_angle = 32'(signed'(cfg_ch.data[pcaw_pkg::ANG_W-1:0]));
          default: ;
        endcase
      end
      // Input transfers
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == pcaw_pkg::ACT_RESET) begin
          integ = 0; last_err = 0; tgt_angle = in_ch.measured;
        end else if (in_ch.action == pcaw_pkg::ACT_LINEAR ||
                     in_ch.action == pcaw_pkg::ACT_CIRCULAR) begin
          if (in_ch.step_time == '0) begin
            drive_q.push_back('0);
          end else if (in_ch.action == pcaw_pkg::ACT_LINEAR) begin
            err = 32'(clampl(longint'(in_ch.setpoint) - longint'(in_ch.measured),
                             I32MIN, I32MAX));
            drive_q.push_back(pid_update(err, in_ch.step_time, 64'(pcaw_pkg::LIN_ILIM)));
          end else begin
            inc = clampl((longint'(in_ch.setpoint) * longint'(in_ch.step_time)) >>> 16,
                         -PI_L, PI_L);
            tgt_angle = 32'(wrap_pi(longint'(tgt_angle) + inc));
            err = 32'(wrap_pi(longint'(tgt_angle) - longint'(in_ch.measured)));
            drive_q.push_back(pid_update(err, in_ch.step_time, 64'(pcaw_pkg::CIRC_ILIM)));
          end
        end
      end
      // Result transfers
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected drive %0d", out_ch.drive);
        end else begin
          if (out_ch.drive !== drive_q[0]) begin
            fail_count++;
            if (fail_count <= 10)
              $display("drive mismatch: expected %0d, got %0d", drive_q[0], out_ch.drive);
          end
          void'(drive_q.pop_front());
        end
      end
    end
    drives_pending = drive_q.size();
  end
endmodule

>>> verif/tb.sv
// Testbench top for pid_controller_angle_wrap_core: clock, reset, stimulus and verdict.
// Depends on pcaw_pkg, pcaw_if, pcaw_checker and the core.
`timescale 1ns / 1ps

module tb;

  logic clk = 0;
  logic rst = 1;
  int   fail_count, drives_pending;
  bit   no_idle = 0;
  int   quiet_cycles = 0;

  pcaw_in_if  in_ch();
  pcaw_out_if out_ch();
  pcaw_cfg_if cfg_ch();

  pid_controller_angle_wrap_core dut (.clk(clk), .rst(rst), .in_ch(in_ch),
                                      .out_ch(out_ch), .cfg_ch(cfg_ch));

  pcaw_checker chk (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
                    .fail_count(fail_count), .drives_pending(drives_pending));

  always #5 clk = ~clk;

  // Result side backpressure
  always @(posedge clk)
    out_ch.ready <= no_idle || ($urandom_range(99) >= 31);

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] act, logic [31:0] sp, logic [31:0] meas,
                           logic [23:0] dt);
    in_ch.valid <= 1'b1; in_ch.action <= act;
    in_ch.setpoint <= sp; in_ch.measured <= meas; in_ch.step_time <= dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!no_idle && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [pcaw_pkg::IDX_W-1:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drain results, then let any result-free item finish inside the core
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (drives_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic logic [23:0] rnd_dt();
    case ($urandom_range(9))
      0: return '0;
      1, 2: return 24'($urandom);
      3: return 24'hffffff;
      default: return 24'($urandom_range(1, 1 << 16));
    endcase
  endfunction

  task automatic random_items(int n);
    int r;
    logic [31:0] meas;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      meas = ($urandom_range(3) == 0) ? rnd_val()
             : 32'($signed($urandom_range(0, 411774)) - 205887);
      if (r < 44)
        send_item(pcaw_pkg::ACT_LINEAR, rnd_val(), rnd_val(), rnd_dt());
      else if (r < 90)
        send_item(pcaw_pkg::ACT_CIRCULAR, rnd_val(), meas, rnd_dt());
      else if (r < 97)
        send_item(pcaw_pkg::ACT_RESET, rnd_val(), meas, rnd_dt());
      else
        send_item(pcaw_pkg::ACT_UNUSED, rnd_val(), rnd_val(), rnd_dt());
    end
  endtask

  task automatic load_gains(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                            logic [31:0] lo, logic [31:0] hi, logic [31:0] ang);
    write_reg(pcaw_pkg::REG_GAIN_P, p);
    write_reg(pcaw_pkg::REG_GAIN_I, i);
    write_reg(pcaw_pkg::REG_GAIN_D, d);
    write_reg(pcaw_pkg::REG_OUT_MIN, lo);
    write_reg(pcaw_pkg::REG_OUT_MAX, hi);
    write_reg(pcaw_pkg::REG_START_ANGLE, ang);
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.action = pcaw_pkg::ACT_LINEAR; in_ch.setpoint = '0;
    in_ch.measured = '0; in_ch.step_time = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = pcaw_pkg::REG_GAIN_P; cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: default registers first, then moderate gains
    send_item(pcaw_pkg::ACT_LINEAR, 32'h00010000, '0, 24'h010000);
    drain();
    load_gains(32'h00018000, 32'h00004000, 32'h00000800, pcaw_pkg::OUT_MIN_RST,
               pcaw_pkg::OUT_MAX_RST, 32'h00020000);
    send_item(pcaw_pkg::ACT_LINEAR, 32'h7fffffff, 32'h80000000, 24'hffffff);
    send_item(pcaw_pkg::ACT_LINEAR, 32'h80000000, 32'h7fffffff, 24'h000001);
    send_item(pcaw_pkg::ACT_LINEAR, 32'h00050000, 32'h00010000, 24'h000000);
    send_item(pcaw_pkg::ACT_LINEAR, 32'h00640000, '0, 24'h0a0000);  // integral to its limit
    send_item(pcaw_pkg::ACT_CIRCULAR, 32'h7fffffff, 32'h00030000, 24'hffffff);  // rate sat
    send_item(pcaw_pkg::ACT_CIRCULAR, 32'h80000000, 32'hfffd0000, 24'h008000);
    send_item(pcaw_pkg::ACT_CIRCULAR, 32'h00010000, 32'h7fffffff, 24'h000000);
    send_item(pcaw_pkg::ACT_CIRCULAR, 32'h00000000, 32'h80000000, 24'h000001);
    send_item(pcaw_pkg::ACT_CIRCULAR, 32'h00100000, 32'h00032437, 24'h010000);
    send_item(pcaw_pkg::ACT_RESET, '0, 32'h00500000, '0);   // target loaded without wrap
    send_item(pcaw_pkg::ACT_CIRCULAR, 32'h00001000, 32'hfffcdbc9, 24'h004000);
    send_item(pcaw_pkg::ACT_UNUSED, 32'hffffffff, 32'hffffffff, 24'hffffff);
    send_item(pcaw_pkg::ACT_CIRCULAR, 32'h00400000, '0, 24'h100000);  // circular limit
    send_item(pcaw_pkg::ACT_RESET, 32'hffffffff, 32'h80000000, 24'hffffff);
    send_item(pcaw_pkg::ACT_LINEAR, '0, '0, 24'h000001);
    drain();

    // Phases of register settings, extremes and crossed limits among them
    load_gains(32'h00020000, 32'h00008000, 32'h00000100, 32'hff000000, 32'h01000000,
               32'h0003243f);
    random_items(250);
    send_item(pcaw_pkg::ACT_LINEAR, 32'h00010000, '0, 24'h1000);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (drives_pending != 0) @(posedge clk);   // sender holds off until all results are in
    random_items(50);
    drain();
    load_gains(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'hfffcdbc1);
    random_items(250);
    drain();
    load_gains(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
               $urandom);
    random_items(250);
    drain();
    no_idle = 1;
    load_gains(32'h00010000, 32'hfff00000, 32'h00100000, 32'h00010000, 32'hffff0000,
               $urandom);
    random_items(300);
    drain();
    no_idle = 0;
    load_gains($urandom, $urandom, $urandom, rnd_val(), rnd_val(), $urandom);
    random_items(250);
    drain();
    load_gains(32'h0000c000, 32'h00002000, 32'hffffc000, 32'hfff80000, 32'h00080000, '0);
    random_items(380);
    drain();

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
